/* sv/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg: shared types and constants for timed resource admission
// Field widths, status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int MACH_W = 4;
  localparam int TIME_W = 31;
  localparam int AMT_W  = 31;
  localparam int END_W  = 32;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_CAP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  localparam logic [AMT_W-1:0] CAP_MAX = {AMT_W{1'b1}};

  // command handed from front to back
  typedef struct packed {
    logic              is_req;
    logic [MACH_W-1:0] machine;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] duration;
    logic [AMT_W-1:0]  amount;
  } cmd_t;

endpackage

/* sv/tra_ram.sv */
// ----------------------------------------------------------------------------
// tra_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module tra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* sv/tra_front.sv */
// ----------------------------------------------------------------------------
// tra_front: input stage and command queue
// Drops out-of-range machines and queues commands for the back end.
// ----------------------------------------------------------------------------
module tra_front #(
  parameter int MACHINES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tra_pkg::cmd_t   in_cmd,
  output logic            q_valid,
  input  logic            q_pop,
  output tra_pkg::cmd_t   q_cmd
);
  import tra_pkg::*;

  localparam int QD = 2;

  cmd_t      q_r [QD];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic       push, keep;

  assign in_ready = (cnt_r != 2'(QD));
  assign keep     = ({{(32-MACH_W){1'b0}}, in_cmd.machine} < 32'(MACHINES));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_r];

  // queue pointers
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= in_cmd;
    end
  end
endmodule

/* sv/tra_back.sv */
// ----------------------------------------------------------------------------
// tra_back: slot scan engine
// Releases expired grants of one machine, then admits or refuses; load items set capacity.
// ----------------------------------------------------------------------------
module tra_back #(
  parameter int MACHINES      = 16,
  parameter int PENDING_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  tra_pkg::cmd_t             q_cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tra_pkg::STAT_W-1:0] out_status,
  output logic [tra_pkg::AMT_W-1:0]  out_remaining
);
  import tra_pkg::*;

  localparam int MW    = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int SW    = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int NS    = MACHINES * PENDING_SLOTS;
  localparam int AW    = (NS > 1) ? $clog2(NS) : 1;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                   st_r, st_nxt;
  cmd_t                     cmd_r;
  logic [SW:0]              k_r, k_nxt;
  logic [AMT_W-1:0]         cap_r [MACHINES];
  logic [AMT_W-1:0]         acc_r, acc_nxt;
  logic [PENDING_SLOTS-1:0] vld_r [MACHINES];
  logic                     free_f_r, free_f_nxt;
  logic [SW-1:0]            free_r, free_nxt;
  logic [AW-1:0]            ram_addr;
  logic                     ram_we;
  logic [END_W-1:0]         end_rd;
  logic [AMT_W-1:0]         amt_rd;
  logic [END_W-1:0]         end_wd;
  logic [MW-1:0]            m_idx;
  logic [AW-1:0]            base;
  logic [AW-1:0]            rd_slot;
  logic [SW-1:0]            ps;
  logic                     rel;
  logic [AMT_W:0]           sum;
  logic                     admit, busy_out;

  assign m_idx   = cmd_r.machine[MW-1:0];
  assign base    = AW'(32'(m_idx) * 32'(PENDING_SLOTS));
  assign rd_slot = base + AW'(k_r[SW-1:0]);
  assign end_wd  = {1'b0, cmd_r.arrival_time} + {1'b0, cmd_r.duration};
  assign admit   = (st_r == S_DONE) && !(acc_r < cmd_r.amount) && free_f_r;
  assign ram_we  = admit && !busy_out;
  assign ram_addr = ram_we ? base + AW'(free_r) : rd_slot;

  tra_ram #(.WIDTH(END_W), .DEPTH(DEPTH)) u_end (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(end_wd), .rdata(end_rd));
  tra_ram #(.WIDTH(AMT_W), .DEPTH(DEPTH)) u_amt (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cmd_r.amount), .rdata(amt_rd));

  // slot read is registered: slot k_r-1 data now on rdata
  assign ps  = k_r[SW-1:0] - SW'(1);
  assign rel = vld_r[m_idx][ps] && (end_rd <= {1'b0, cmd_r.arrival_time});
  assign sum = {1'b0, acc_r} + {1'b0, amt_rd};
  assign busy_out = out_valid && !out_ready;
  assign q_pop = (st_r == S_IDLE) && q_valid;

  // sequencer
  always_comb begin
    st_nxt     = st_r;
    k_nxt      = k_r;
    acc_nxt    = acc_r;
    free_f_nxt = free_f_r;
    free_nxt   = free_r;
    case (st_r)
      S_IDLE: begin
        k_nxt = '0;
        if (q_valid) begin
          st_nxt = q_cmd.is_req ? S_READ : S_IDLE;
        end
      end
      S_READ: begin
        acc_nxt    = cap_r[m_idx];
        free_f_nxt = 1'b0;
        free_nxt   = '0;
        k_nxt      = (SW+1)'(1);
        st_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (rel) begin
          acc_nxt = sum[AMT_W] ? CAP_MAX : sum[AMT_W-1:0];
        end
        if (!free_f_r && (rel || !vld_r[m_idx][ps])) begin
          free_f_nxt = 1'b1;
          free_nxt   = ps;
        end
        if (k_r == (SW+1)'(PENDING_SLOTS)) begin
          st_nxt = S_DONE;
        end else begin
          k_nxt = k_r + (SW+1)'(1);
        end
      end
      S_DONE: begin
        if (!busy_out) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < MACHINES; i++) begin
        cap_r[i] <= '0;
        vld_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      // load item writes capacity directly
      if (q_pop && !q_cmd.is_req) begin
        cap_r[q_cmd.machine[MW-1:0]] <= q_cmd.amount;
      end
      if (st_r == S_SCAN && rel) begin
        vld_r[m_idx][ps] <= 1'b0;
      end
      // result and commit
      if (st_r == S_DONE && !busy_out) begin
        out_valid <= 1'b1;
        if (acc_r < cmd_r.amount) begin
          out_status    <= ST_NO_CAP;
          out_remaining <= acc_r;
          cap_r[m_idx]  <= acc_r;
        end else if (!free_f_r) begin
          out_status    <= ST_FULL;
          out_remaining <= acc_r;
          cap_r[m_idx]  <= acc_r;
        end else begin
          out_status    <= ST_GRANTED;
          out_remaining <= acc_r - cmd_r.amount;
          cap_r[m_idx]  <= acc_r - cmd_r.amount;
          vld_r[m_idx][free_r] <= 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    k_r      <= k_nxt;
    acc_r    <= acc_nxt;
    free_f_r <= free_f_nxt;
    free_r   <= free_nxt;
  end
endmodule

/* sv/timed_resource_admission.sv */
// ----------------------------------------------------------------------------
// timed_resource_admission: per-machine capacity admission with timed release
//
//   channel  dir  fields
//   in_*     in   tdata: machine, arrival_time, duration, amount; tuser: mode
//   out_*    out  tdata: remaining; tuser: status
//
// A request is served by a scan that reads one grant slot a cycle from the
// slot RAMs. A load item writes its machine's capacity as it is popped.
// Reset clears all capacities and grant valid bits at once.
// A two-entry queue decouples input from the scan; a waiting result stalls
// the back end, and the input once the queue is full.
// ----------------------------------------------------------------------------
module timed_resource_admission #(
  parameter int MACHINES      = 16,
  parameter int PENDING_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // machine[3:0], arrival[34:4], duration[65:35], amount[96:66]
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // remaining[30:0]
  output logic [1:0]   out_tuser   // status
);
  import tra_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic [AMT_W-1:0] rem;

  // tdata: machine[3:0], arrival_time[34:4], duration[65:35], amount[96:66]
  assign in_cmd.is_req       = in_tuser;
  assign in_cmd.machine      = in_tdata[3:0];
  assign in_cmd.arrival_time = in_tdata[34:4];
  assign in_cmd.duration     = in_tdata[65:35];
  assign in_cmd.amount       = in_tdata[96:66];

  tra_front #(.MACHINES(MACHINES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  tra_back #(.MACHINES(MACHINES), .PENDING_SLOTS(PENDING_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(out_tuser), .out_remaining(rem));

  assign out_tdata = {1'b0, rem};
endmodule
